// ----- design/dart_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dart_pkg: shared types and constants for the delta address result table
// Request codes, sizing defaults and the controller/datapath command bundle.
// ----------------------------------------------------------------------------
package dart_pkg;

    localparam int unsigned MAX_ENTRIES_DEF = 4096;
    localparam int unsigned MAX_LANES_DEF   = 64;
    localparam int unsigned LANE_SPAN_DEF   = 65535;

    localparam logic [15:0] OFFSET_MASK = 16'hFFFF;

    localparam logic [2:0] REQ_ADD    = 3'd0;
    localparam logic [2:0] REQ_GET    = 3'd1;
    localparam logic [2:0] REQ_SEARCH = 3'd2;
    localparam logic [2:0] REQ_RANGE  = 3'd3;
    localparam logic [2:0] REQ_CLEAR  = 3'd4;

    // Datapath operation selects.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,      // capture request
        OP_ADD_CHECK,  // read current lane base
        OP_ADD_WRITE,  // decide lane, write entry
        OP_RD_ENTRY,   // read entry at rd index
        OP_RD_BASE,    // read lane base of that entry
        OP_ADDR,       // form full address
        OP_GET_DONE,
        OP_SRCH_INIT,
        OP_SRCH_STEP,  // compare mid address, narrow bounds
        OP_SRCH_DONE,
        OP_RNG_FIRST,  // capture start, aim at last entry
        OP_RNG_DONE,
        OP_CLEAR,
        OP_BAD
    } dart_op_t;

    typedef struct packed {
        dart_op_t   op;
        logic       rd_last;   // read address select: last entry instead of index/mid
        logic       rd_mid;
    } dart_cmd_t;

    typedef struct packed {
        logic [2:0] req;
        logic       srch_busy; // lo < hi
    } dart_status_t;

endpackage
`default_nettype wire

// ----- design/dart_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dart_datapath: entry memories, lane bases, counters and result registers
// Executes one operation per cycle as selected by the controller.
// ----------------------------------------------------------------------------
module dart_datapath #(
    parameter int unsigned MAX_ENTRIES = dart_pkg::MAX_ENTRIES_DEF,
    parameter int unsigned MAX_LANES   = dart_pkg::MAX_LANES_DEF,
    parameter int unsigned LANE_SPAN   = dart_pkg::LANE_SPAN_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire dart_pkg::dart_cmd_t cmd,
    output dart_pkg::dart_status_t   status,
    input  wire logic [2:0]          in_req,
    input  wire logic [63:0]         in_addr,
    input  wire logic [31:0]         in_size,
    input  wire logic [15:0]         in_data,
    input  wire logic [11:0]         in_index,
    output logic                     res_ok,
    output logic [63:0]              res_address,
    output logic [31:0]              res_size,
    output logic [15:0]              res_data,
    output logic [12:0]              res_index,
    output logic [63:0]              res_end
);
    localparam int unsigned EW = $clog2(MAX_ENTRIES);
    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned LW = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
    localparam int unsigned LCW = $clog2(MAX_LANES + 1);

    logic [31:0]   size_mem  [MAX_ENTRIES];
    logic [31:0]   offd_mem  [MAX_ENTRIES];
    logic [LW-1:0] lane_mem  [MAX_ENTRIES];
    logic [63:0]   base_mem  [MAX_LANES];

    logic [CW-1:0]  entry_count_reg;
    logic [LCW-1:0] lane_count_reg;

    logic [2:0]  req_reg;
    logic [63:0] addr_reg;
    logic [31:0] size_reg;
    logic [15:0] data_reg;
    logic [11:0] index_reg;

    logic [31:0]   rd_size_reg;
    logic [31:0]   rd_offd_reg;
    logic [LW-1:0] rd_lane_reg;
    logic [63:0]   rd_base_reg;
    logic [63:0]   rd_addr_reg;

    logic [CW-1:0] lo_reg, hi_reg;
    logic [CW-1:0] mid;
    logic [EW-1:0] rd_idx;
    logic [LW-1:0] cur_lane;
    logic [63:0]   diff;
    logic          need_lane;

    assign mid = CW'((CW+1)'(lo_reg) + (CW+1)'(hi_reg) >> 1);
    assign cur_lane = LW'(lane_count_reg - LCW'(1));
    assign diff = addr_reg - rd_base_reg;
    assign need_lane = (addr_reg < rd_base_reg) || (diff > 64'(LANE_SPAN));

    always_comb begin
        if (cmd.rd_last) begin
            rd_idx = EW'(entry_count_reg - CW'(1));
        end else if (cmd.rd_mid) begin
            rd_idx = EW'(mid);
        end else if (req_reg == dart_pkg::REQ_RANGE) begin
            rd_idx = '0;
        end else begin
            rd_idx = EW'(index_reg);
        end
    end

    assign status.req = req_reg;
    assign status.srch_busy = lo_reg < hi_reg;

    // Memories: registered reads, single write port each.
    always_ff @(posedge aclk) begin
        if (cmd.op == dart_pkg::OP_RD_ENTRY) begin
            rd_size_reg <= size_mem[rd_idx];
            rd_offd_reg <= offd_mem[rd_idx];
            rd_lane_reg <= lane_mem[rd_idx];
        end
        if (cmd.op == dart_pkg::OP_RD_BASE) begin
            rd_base_reg <= base_mem[rd_lane_reg];
        end else if (cmd.op == dart_pkg::OP_ADD_CHECK) begin
            rd_base_reg <= base_mem[cur_lane];
        end
        if (cmd.op == dart_pkg::OP_ADD_WRITE && entry_count_reg < CW'(MAX_ENTRIES)) begin
            if (lane_count_reg == '0) begin
                base_mem[0] <= addr_reg;
            end else if (need_lane && lane_count_reg < LCW'(MAX_LANES)) begin
                base_mem[LW'(lane_count_reg)] <= addr_reg;
            end
            if (lane_count_reg == '0 || !need_lane || lane_count_reg < LCW'(MAX_LANES)) begin
                size_mem[EW'(entry_count_reg)] <= size_reg;
                if (lane_count_reg == '0 || need_lane) begin
                    offd_mem[EW'(entry_count_reg)] <= {16'h0, data_reg};
                    lane_mem[EW'(entry_count_reg)] <= (lane_count_reg == '0) ? '0
                                                      : LW'(lane_count_reg);
                end else begin
                    offd_mem[EW'(entry_count_reg)] <= {diff[15:0] & dart_pkg::OFFSET_MASK,
                                                       data_reg};
                    lane_mem[EW'(entry_count_reg)] <= cur_lane;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
            lane_count_reg  <= '0;
        end else begin
            case (cmd.op)
                dart_pkg::OP_ADD_WRITE: begin
                    if (entry_count_reg < CW'(MAX_ENTRIES)) begin
                        if (lane_count_reg == '0) begin
                            lane_count_reg  <= LCW'(1);
                            entry_count_reg <= entry_count_reg + CW'(1);
                        end else if (!need_lane) begin
                            entry_count_reg <= entry_count_reg + CW'(1);
                        end else if (lane_count_reg < LCW'(MAX_LANES)) begin
                            lane_count_reg  <= lane_count_reg + LCW'(1);
                            entry_count_reg <= entry_count_reg + CW'(1);
                        end
                    end
                end
                dart_pkg::OP_CLEAR: begin
                    entry_count_reg <= '0;
                    lane_count_reg  <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            dart_pkg::OP_LATCH: begin
                req_reg   <= in_req;
                addr_reg  <= in_addr;
                size_reg  <= in_size;
                data_reg  <= in_data;
                index_reg <= in_index;
                res_ok      <= 1'b0;
                res_address <= '0;
                res_size    <= '0;
                res_data    <= '0;
                res_index   <= '0;
                res_end     <= '0;
            end
            dart_pkg::OP_ADD_WRITE: begin
                res_ok <= (entry_count_reg < CW'(MAX_ENTRIES)) &&
                          (lane_count_reg == '0 || !need_lane ||
                           lane_count_reg < LCW'(MAX_LANES));
            end
            dart_pkg::OP_ADDR: begin
                rd_addr_reg <= rd_base_reg + 64'(rd_offd_reg[31:16]);
            end
            dart_pkg::OP_GET_DONE: begin
                res_ok      <= 13'(index_reg) < 13'(entry_count_reg);
                if (13'(index_reg) < 13'(entry_count_reg)) begin
                    res_address <= rd_addr_reg;
                    res_size    <= rd_size_reg;
                    res_data    <= rd_offd_reg[15:0];
                end
            end
            dart_pkg::OP_SRCH_INIT: begin
                lo_reg <= '0;
                hi_reg <= entry_count_reg;
            end
            dart_pkg::OP_SRCH_STEP: begin
                if (rd_addr_reg < addr_reg) begin
                    lo_reg <= mid + CW'(1);
                end else begin
                    hi_reg <= mid;
                end
            end
            dart_pkg::OP_SRCH_DONE: begin
                res_ok    <= 1'b1;
                res_index <= 13'(lo_reg);
            end
            dart_pkg::OP_RNG_FIRST: begin
                res_address <= rd_addr_reg;
            end
            dart_pkg::OP_RNG_DONE: begin
                res_ok <= entry_count_reg != '0;
                if (entry_count_reg == '0) begin
                    res_address <= '0;
                    res_end     <= '0;
                end else begin
                    res_end <= rd_addr_reg + 64'(rd_size_reg);
                end
            end
            dart_pkg::OP_CLEAR: begin
                res_ok <= 1'b1;
            end
            default: begin
            end
        endcase
    end
endmodule
`default_nettype wire

// ----- design/dart_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dart_ctrl: request sequencer
// Walks each request through its read and compare steps, then holds the result.
// ----------------------------------------------------------------------------
module dart_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    input  wire dart_pkg::dart_status_t status,
    output dart_pkg::dart_cmd_t         cmd
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_DISPATCH, ST_ADD_WR, ST_RD_ENTRY, ST_RD_BASE, ST_ADDR,
        ST_SRCH_TEST, ST_RNG_LAST, ST_FINISH, ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   last_reg, last_next;      // range request is on its second read
    logic   m_valid_next;

    always_comb begin
        state_next   = state_reg;
        last_next    = last_reg;
        m_valid_next = m_valid;
        cmd.op       = dart_pkg::OP_NONE;
        cmd.rd_last  = last_reg;
        cmd.rd_mid   = status.req == dart_pkg::REQ_SEARCH;
        s_ready      = state_reg == ST_IDLE;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = dart_pkg::OP_LATCH;
                    last_next  = 1'b0;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (status.req)
                    dart_pkg::REQ_ADD: begin
                        cmd.op = dart_pkg::OP_ADD_CHECK;
                        state_next = ST_ADD_WR;
                    end
                    dart_pkg::REQ_GET, dart_pkg::REQ_RANGE: state_next = ST_RD_ENTRY;
                    dart_pkg::REQ_SEARCH: begin
                        cmd.op = dart_pkg::OP_SRCH_INIT;
                        state_next = ST_SRCH_TEST;
                    end
                    dart_pkg::REQ_CLEAR: begin
                        cmd.op = dart_pkg::OP_CLEAR;
                        state_next = ST_OUT;
                        m_valid_next = 1'b1;
                    end
                    default: begin
                        cmd.op = dart_pkg::OP_BAD;
                        state_next = ST_OUT;
                        m_valid_next = 1'b1;
                    end
                endcase
            end
            ST_ADD_WR: begin
                cmd.op = dart_pkg::OP_ADD_WRITE;
                state_next = ST_OUT;
                m_valid_next = 1'b1;
            end
            ST_SRCH_TEST: begin
                state_next = status.srch_busy ? ST_RD_ENTRY : ST_FINISH;
            end
            ST_RD_ENTRY: begin
                cmd.op = dart_pkg::OP_RD_ENTRY;
                state_next = ST_RD_BASE;
            end
            ST_RD_BASE: begin
                cmd.op = dart_pkg::OP_RD_BASE;
                state_next = ST_ADDR;
            end
            ST_ADDR: begin
                cmd.op = dart_pkg::OP_ADDR;
                if (status.req == dart_pkg::REQ_SEARCH) begin
                    state_next = ST_FINISH;
                end else if (status.req == dart_pkg::REQ_RANGE && !last_reg) begin
                    state_next = ST_RNG_LAST;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_RNG_LAST: begin
                cmd.op = dart_pkg::OP_RNG_FIRST;
                last_next = 1'b1;
                state_next = ST_RD_ENTRY;
            end
            ST_FINISH: begin
                if (status.req == dart_pkg::REQ_SEARCH) begin
                    if (status.srch_busy && !last_reg) begin
                        cmd.op = dart_pkg::OP_SRCH_STEP;
                        last_next = 1'b1;
                    end else begin
                        cmd.op = dart_pkg::OP_SRCH_DONE;
                        m_valid_next = 1'b1;
                        state_next = ST_OUT;
                    end
                    if (status.srch_busy && !last_reg) state_next = ST_SRCH_TEST;
                end else begin
                    cmd.op = (status.req == dart_pkg::REQ_GET) ? dart_pkg::OP_GET_DONE
                                                               : dart_pkg::OP_RNG_DONE;
                    m_valid_next = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        // Search: last_reg marks "step already taken for this probe".
        if (state_reg == ST_SRCH_TEST) begin
            last_next = 1'b0;
        end
        if (status.req == dart_pkg::REQ_SEARCH) begin
            cmd.rd_last = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            last_reg  <= 1'b0;
            m_valid   <= 1'b0;
        end else begin
            state_reg <= state_next;
            last_reg  <= last_next;
            m_valid   <= m_valid_next;
        end
    end
endmodule
`default_nettype wire

// ----- design/delta_address_result_table.sv -----
`default_nettype none
// One request at a time; a search takes up to 13 probes at 4096 entries, and each probe
// costs an entry read, a lane base read and an add.
// A new request is accepted only back in idle, once the result handshake is done.
// Reset (aresetn low, synchronous) empties the table; memories are not cleared.
// ----------------------------------------------------------------------------
// delta_address_result_table: compact store of search hits
// Entries hold 16-bit offsets from lane bases; supports add/get/search/range/clear.
// ----------------------------------------------------------------------------
module delta_address_result_table #(
    parameter int unsigned MAX_ENTRIES = dart_pkg::MAX_ENTRIES_DEF,
    parameter int unsigned MAX_LANES   = dart_pkg::MAX_LANES_DEF,
    parameter int unsigned LANE_SPAN   = dart_pkg::LANE_SPAN_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_req_type,
    input  wire logic [63:0] s_query_address,
    input  wire logic [31:0] s_item_size,
    input  wire logic [15:0] s_item_data,
    input  wire logic [11:0] s_entry_index,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_ok,
    output logic [63:0]      m_found_address,
    output logic [31:0]      m_found_size,
    output logic [15:0]      m_found_data,
    output logic [12:0]      m_found_index,
    output logic [63:0]      m_range_end
);
    dart_pkg::dart_cmd_t    cmd;
    dart_pkg::dart_status_t status;

    dart_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dart_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_LANES   (MAX_LANES),
        .LANE_SPAN   (LANE_SPAN)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .in_req      (s_req_type),
        .in_addr     (s_query_address),
        .in_size     (s_item_size),
        .in_data     (s_item_data),
        .in_index    (s_entry_index),
        .res_ok      (m_ok),
        .res_address (m_found_address),
        .res_size    (m_found_size),
        .res_data    (m_found_data),
        .res_index   (m_found_index),
        .res_end     (m_range_end)
    );

`ifndef SYNTH
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("request taken while result pending");
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_found_index) && $stable(m_ok))
        else $error("result changed while stalled");
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready && !m_valid) else $error("accept sequencing");
`endif
endmodule
`default_nettype wire

// ----- tb/tb_delta_address_result_table.sv -----
// ----------------------------------------------------------------------------
// tb_delta_address_result_table: request/response check of the hit table
// Drives add/get/search/range/clear and unknown requests with bursty valid and a stalling
// ready, predicts every response from a local model of lanes and entries,
// and compares each response field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_delta_address_result_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NUM_ENTRIES = 4096;
    localparam int unsigned NUM_LANES   = 64;
    localparam longint unsigned SPAN    = 64'd65535;
    localparam int unsigned CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [63:0] query_address;
        logic [31:0] item_size;
        logic [15:0] item_data;
        logic [11:0] entry_index;
    } request_t;

    typedef struct packed {
        logic        ok;
        logic [63:0] found_address;
        logic [31:0] found_size;
        logic [15:0] found_data;
        logic [12:0] found_index;
        logic [63:0] range_end;
    } response_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_req_type = '0;
    logic [63:0] s_query_address = '0;
    logic [31:0] s_item_size = '0;
    logic [15:0] s_item_data = '0;
    logic [11:0] s_entry_index = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_ok;
    logic [63:0] m_found_address;
    logic [31:0] m_found_size;
    logic [15:0] m_found_data;
    logic [12:0] m_found_index;
    logic [63:0] m_range_end;

    delta_address_result_table dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_req_type(s_req_type), .s_query_address(s_query_address),
        .s_item_size(s_item_size), .s_item_data(s_item_data),
        .s_entry_index(s_entry_index),
        .m_valid(m_valid), .m_ready(m_ready), .m_ok(m_ok),
        .m_found_address(m_found_address), .m_found_size(m_found_size),
        .m_found_data(m_found_data), .m_found_index(m_found_index),
        .m_range_end(m_range_end)
    );

    always #2 aclk = ~aclk;

    // predictor state
    logic [31:0] hit_size [NUM_ENTRIES];
    logic [15:0] hit_offset [NUM_ENTRIES];
    logic [15:0] hit_data [NUM_ENTRIES];
    logic [5:0]  hit_lane [NUM_ENTRIES];
    logic [63:0] lane_base [NUM_LANES];
    int unsigned hit_count = 0;
    int unsigned lane_total = 0;

    request_t  pending_requests [$];
    response_t expected_responses [$];
    int unsigned errors = 0;
    int unsigned cycles = 0;
    int unsigned hold_off = 0;

    function automatic logic [63:0] hit_address(int unsigned i);
        return lane_base[hit_lane[i]] + {48'd0, hit_offset[i]};
    endfunction

    function automatic response_t predict_response(request_t r);
        response_t   rsp;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int unsigned lane;
        bit          room;
        rsp = '0;
        case (r.req_type)
            dart_pkg::REQ_ADD: begin
                room = hit_count < NUM_ENTRIES;
                if (room) begin
                    if (lane_total == 0) begin
                        lane = 0;
                        lane_base[0] = r.query_address;
                        lane_total = 1;
                    end else if (r.query_address < lane_base[lane_total - 1] ||
                            r.query_address - lane_base[lane_total - 1] > SPAN) begin
                        if (lane_total >= NUM_LANES) begin
                            room = 1'b0;
                        end else begin
                            lane = lane_total;
                            lane_base[lane] = r.query_address;
                            lane_total++;
                        end
                    end else begin
                        lane = lane_total - 1;
                    end
                end
                if (room) begin
                    hit_size[hit_count] = r.item_size;
                    hit_offset[hit_count] = 16'(r.query_address - lane_base[lane]);
                    hit_data[hit_count] = r.item_data;
                    hit_lane[hit_count] = 6'(lane);
                    hit_count++;
                end
                rsp.ok = room;
            end
            dart_pkg::REQ_GET: begin
                if (r.entry_index < hit_count) begin
                    rsp.ok = 1'b1;
                    rsp.found_address = hit_address(r.entry_index);
                    rsp.found_size = hit_size[r.entry_index];
                    rsp.found_data = hit_data[r.entry_index];
                end
            end
            dart_pkg::REQ_SEARCH: begin
                lo = 0;
                hi = hit_count;
                while (lo < hi) begin
                    mid = (lo + hi) / 2;
                    if (hit_address(mid) < r.query_address) lo = mid + 1;
                    else hi = mid;
                end
                rsp.ok = 1'b1;
                rsp.found_index = 13'(lo);
            end
            dart_pkg::REQ_RANGE: begin
                if (hit_count > 0) begin
                    rsp.ok = 1'b1;
                    rsp.found_address = hit_address(0);
                    rsp.range_end = hit_address(hit_count - 1) + {32'd0, hit_size[hit_count - 1]};
                end
            end
            dart_pkg::REQ_CLEAR: begin
                hit_count = 0;
                lane_total = 0;
                rsp.ok = 1'b1;
            end
            default: ;
        endcase
        return rsp;
    endfunction

    function automatic request_t make_request(logic [2:0] kind, logic [63:0] addr,
                                              logic [11:0] idx);
        request_t r;
        r.req_type = kind;
        r.query_address = addr;
        r.item_size = $urandom;
        r.item_data = 16'($urandom);
        r.entry_index = idx;
        return r;
    endfunction

    task automatic queue_request(request_t r);
        pending_requests = {pending_requests, r};
    endtask

    // Driver: bursts of requests separated by random gaps.
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!(s_valid && !s_ready)) begin
            if (s_valid && s_ready) pending_requests.pop_front();
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_requests.size() > (s_valid && s_ready ? 0 : 0) &&
                         pending_requests.size() > 0) begin
                s_valid <= 1'b1;
                {s_req_type, s_query_address, s_item_size, s_item_data, s_entry_index}
                    <= pending_requests[0];
                expected_responses = {expected_responses,
                                      predict_response(pending_requests[0])};
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                end else begin
                    burst_left--;
                    if (burst_left == 0 && $urandom_range(0, 2) != 0)
                        gap_left = $urandom_range(1, 40);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern plus one long hold-off.
    int unsigned stall_phase = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off--;
            m_ready <= 1'b0;
        end else begin
            stall_phase++;
            case (stall_phase[9:8])
                2'd0: m_ready <= 1'b1;
                2'd1: m_ready <= ($urandom_range(0, 3) != 0);
                2'd2: m_ready <= (stall_phase[2:0] != 3'd5);
                default: m_ready <= ($urandom_range(0, 1) != 0);
            endcase
        end
    end

    // Monitor
    always @(posedge aclk) begin
        response_t got;
        response_t want;
        cycles++;
        if (aresetn && m_valid && m_ready) begin
            got = {m_ok, m_found_address, m_found_size, m_found_data, m_found_index,
                   m_range_end};
            if (expected_responses.size() == 0) begin
                $display("%0t: unexpected response %h", $time, got);
                errors++;
            end else begin
                want = expected_responses.pop_front();
                if (got.ok !== want.ok) begin
                    $display("%0t: ok exp %h got %h", $time, want.ok, got.ok);
                    errors++;
                end
                if (got.found_address !== want.found_address) begin
                    $display("%0t: found_address exp %h got %h", $time,
                             want.found_address, got.found_address);
                    errors++;
                end
                if (got.found_size !== want.found_size) begin
                    $display("%0t: found_size exp %h got %h", $time,
                             want.found_size, got.found_size);
                    errors++;
                end
                if (got.found_data !== want.found_data) begin
                    $display("%0t: found_data exp %h got %h", $time,
                             want.found_data, got.found_data);
                    errors++;
                end
                if (got.found_index !== want.found_index) begin
                    $display("%0t: found_index exp %0d got %0d", $time,
                             want.found_index, got.found_index);
                    errors++;
                end
                if (got.range_end !== want.range_end) begin
                    $display("%0t: range_end exp %h got %h", $time,
                             want.range_end, got.range_end);
                    errors++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL delta_address_result_table");
            $finish;
        end
    end

    initial begin
        logic [63:0] addr;
        logic [63:0] base;
        int unsigned n;
        int unsigned kind;
        int unsigned shadow_count;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty table, extremes, lane rules
        queue_request(make_request(dart_pkg::REQ_RANGE, 64'd0, 12'd0));
        queue_request(make_request(dart_pkg::REQ_GET, 64'd0, 12'd0));
        queue_request(make_request(dart_pkg::REQ_SEARCH, '1, 12'd0));
        queue_request(make_request(dart_pkg::REQ_ADD, 64'h0000_0000_0001_0000, 12'd0));
        queue_request(make_request(dart_pkg::REQ_ADD, 64'h0000_0000_0001_FFFF, 12'd0));
        queue_request(make_request(dart_pkg::REQ_ADD, 64'h0000_0000_0002_0000, 12'd0));
        queue_request(make_request(dart_pkg::REQ_ADD, 64'h0000_0000_0000_0005, 12'd0));
        queue_request(make_request(dart_pkg::REQ_ADD, '1, 12'd0));
        pending_requests[$].item_size = '1;
        pending_requests[$].item_data = '1;
        queue_request(make_request(dart_pkg::REQ_GET, 64'd0, 12'd1));
        queue_request(make_request(dart_pkg::REQ_GET, 64'd0, 12'd4));
        queue_request(make_request(dart_pkg::REQ_GET, 64'd0, 12'd5));
        queue_request(make_request(dart_pkg::REQ_GET, 64'd0, 12'hFFF));
        queue_request(make_request(dart_pkg::REQ_SEARCH, 64'h0000_0000_0001_FFFF, 12'd0));
        queue_request(make_request(dart_pkg::REQ_SEARCH, 64'd0, 12'd0));
        queue_request(make_request(dart_pkg::REQ_RANGE, 64'd0, 12'd0));
        queue_request(make_request(3'd5, '1, 12'hFFF));
        queue_request(make_request(3'd7, 64'd0, 12'd0));
        queue_request(make_request(dart_pkg::REQ_CLEAR, 64'd0, 12'd0));
        queue_request(make_request(dart_pkg::REQ_RANGE, 64'd0, 12'd0));

        // lane exhaustion: 64 lanes, then the 65th fails
        for (int i = 0; i < 65; i++)
            queue_request(make_request(dart_pkg::REQ_ADD, 64'(i) << 20, 12'd0));
        queue_request(make_request(dart_pkg::REQ_ADD, 64'(63) << 20 | 64'hFFFF, 12'd0));
        queue_request(make_request(dart_pkg::REQ_SEARCH, 64'(30) << 20, 12'd0));
        queue_request(make_request(dart_pkg::REQ_RANGE, 64'd0, 12'd0));
        queue_request(make_request(dart_pkg::REQ_CLEAR, 64'd0, 12'd0));

        // long receiver hold-off once the pipe is busy
        fork
            begin
                repeat (400) @(posedge aclk);
                hold_off = 300;
            end
        join_none

        // random: mostly nondecreasing runs with random content
        shadow_count = 0;
        base = {$urandom, $urandom};
        for (int i = 0; i < 1460; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 50) begin
                n = $urandom_range(0, 19);
                if (n == 0) addr = {$urandom, $urandom};
                else if (n < 4) addr = base + {$urandom, $urandom} % 64'h40000;
                else addr = base + $urandom_range(0, 300);
                base = addr;
                queue_request(make_request(dart_pkg::REQ_ADD, addr, 12'd0));
                shadow_count++;
            end else if (kind < 68) begin
                queue_request(make_request(dart_pkg::REQ_GET, 64'd0,
                    12'($urandom_range(0, shadow_count + 3))));
            end else if (kind < 84) begin
                addr = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                       : base - $urandom_range(0, 2000);
                queue_request(make_request(dart_pkg::REQ_SEARCH, addr, 12'($urandom)));
            end else if (kind < 94) begin
                queue_request(make_request(dart_pkg::REQ_RANGE, {$urandom, $urandom},
                    12'($urandom)));
            end else if (kind < 97) begin
                queue_request(make_request(dart_pkg::REQ_CLEAR, {$urandom, $urandom},
                    12'($urandom)));
                shadow_count = 0;
            end else begin
                queue_request(make_request(3'($urandom_range(5, 7)), {$urandom, $urandom},
                    12'($urandom)));
            end
        end

        wait (pending_requests.size() == 0 && !s_valid);
        wait (expected_responses.size() == 0);
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS delta_address_result_table");
        end else begin
            $display("FAIL delta_address_result_table");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
design/dart_pkg.sv
design/dart_datapath.sv
design/dart_ctrl.sv
design/delta_address_result_table.sv
tb/tb_delta_address_result_table.sv
